// ===== src/sva_pkg.sv =====
// Shared constants, types and codes for the voice allocator.
package sva_pkg;

    localparam int NUM_VOICES  = 16;
    localparam int SLOT_W      = $clog2(NUM_VOICES);
    localparam int CMD_W       = 3;
    localparam int NOTE_W      = 7;
    localparam int SNOTE_W     = NOTE_W + 1;
    localparam int VEL_W       = 10;
    localparam int LEVEL_W     = 16;
    localparam int AGE_W       = 48;
    localparam int MAX_RESULTS = 15;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PH_W        = 2;

    localparam logic [SNOTE_W-1:0] NO_NOTE    = SNOTE_W'(128);
    localparam logic [SLOT_W-1:0]  FIRST_SLOT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(NUM_VOICES - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON    = 3'd0,
        CMD_NOTE_OFF   = 3'd1,
        CMD_VOICE_DONE = 3'd2,
        CMD_LEVEL_REP  = 3'd3,
        CMD_PANIC      = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_START_FM    = 3'd0,
        ACT_START_SUB   = 3'd1,
        ACT_RELEASE_FM  = 3'd2,
        ACT_RELEASE_SUB = 3'd3,
        ACT_RELEASE_ALL = 3'd5
    } act_t;

    // one slot's state as held in the slot memory
    typedef struct packed {
        logic               fm_active;
        logic               sub_active;
        logic [SNOTE_W-1:0] note;
        logic [AGE_W-1:0]   age;
        logic [LEVEL_W-1:0] level;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        fm_active:  1'b0,
        sub_active: 1'b0,
        note:       NO_NOTE,
        age:        '0,
        level:      '0
    };

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_req_t;

    typedef struct packed {
        logic              clear;
        logic              upd;
        logic [SLOT_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        act_t              action;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              stolen;
        logic              last;
    } result_t;

endpackage

// ===== src/synth_voice_allocator_unit.sv =====
// Top level of the polyphonic voice allocator with voice stealing.
// Note_on, accept to last result: sweep of slots 1..15, pick read, one result per cycle,
//   output register; note_off and panic sweep the slots and register their results.
// Requests: one at a time, the next taken once busy is low again; the receiver cannot stall.
// Reset: control clears at once; per-entry written bits make untouched slots read as reset.
module synth_voice_allocator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sva_pkg::CMD_W-1:0]    cmd,
    input  logic [sva_pkg::NOTE_W-1:0]   note,
    input  logic [sva_pkg::VEL_W-1:0]    velocity,
    input  logic                         engine,
    input  logic [sva_pkg::SLOT_W-1:0]   slot_index,
    input  logic [sva_pkg::LEVEL_W-1:0]  level,
    output logic                         strobe,
    output logic [sva_pkg::SLOT_W-1:0]   slot,
    output logic [2:0]                   action,
    output logic [sva_pkg::NOTE_W-1:0]   note_out,
    output logic [sva_pkg::VEL_W-1:0]    velocity_out,
    output logic                         stolen,
    output logic                         last
);
    import sva_pkg::*;

    ram_req_t          ram_req;
    entry_t            rd_entry;
    scan_ctl_t         scan;
    logic              scan_fm;
    logic [SLOT_W-1:0] pick_slot;
    logic              pick_stolen;
    result_t           res;

    // slot state: activity bits, held note, age stamp and reported level per slot
    sva_slot_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rd_entry (rd_entry)
    );

    // candidate search fed by the note_on sweep, one slot per cycle
    sva_steal_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan),
        .entry       (rd_entry),
        .fm          (scan_fm),
        .pick_slot   (pick_slot),
        .pick_stolen (pick_stolen)
    );

    // sequencer: decodes the request, drives memory sweeps, registers results
    sva_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .note        (note),
        .velocity    (velocity),
        .engine      (engine),
        .slot_index  (slot_index),
        .level       (level),
        .busy        (busy),
        .res         (res),
        .req         (ram_req),
        .rd_entry    (rd_entry),
        .scan        (scan),
        .scan_fm     (scan_fm),
        .pick_slot   (pick_slot),
        .pick_stolen (pick_stolen)
    );

    // results come straight from the sequencer's output register
    assign strobe       = res.valid;
    assign slot         = res.slot;
    assign action       = res.action;
    assign note_out     = res.note;
    assign velocity_out = res.velocity;
    assign stolen       = res.stolen;
    assign last         = res.last;

endmodule

// ===== src/sva_slot_ram.sv =====
// Slot state memory: one write port, one read port, registered read data.
module sva_slot_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  sva_pkg::ram_req_t req,
    output sva_pkg::entry_t   rd_entry
);
    import sva_pkg::*;

    entry_t                mem_reg [NUM_VOICES];
    entry_t                rd_data_reg;
    logic [NUM_VOICES-1:0] written_reg;
    logic                  rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    // entries never written since reset read as the reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_entry = rd_written_reg ? rd_data_reg : RESET_ENTRY;

endmodule

// ===== src/sva_steal_scan.sv =====
// Running search over the slots for a free, idle or steal candidate.
module sva_steal_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sva_pkg::scan_ctl_t          ctl,
    input  sva_pkg::entry_t             entry,
    input  logic                        fm,
    output logic [sva_pkg::SLOT_W-1:0]  pick_slot,
    output logic                        pick_stolen
);
    import sva_pkg::*;

    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic               fmi_found_reg;
    logic [SLOT_W-1:0]  fmi_slot_reg;
    logic               subi_found_reg;
    logic [SLOT_W-1:0]  subi_slot_reg;
    logic [LEVEL_W-1:0] min_level_reg;
    logic [SLOT_W-1:0]  min_level_slot_reg;
    logic [AGE_W-1:0]   min_age_reg;
    logic [SLOT_W-1:0]  min_age_slot_reg;
    logic               first;

    assign first = (ctl.idx == FIRST_SLOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg     <= 1'b0;
            free_slot_reg      <= '0;
            fmi_found_reg      <= 1'b0;
            fmi_slot_reg       <= '0;
            subi_found_reg     <= 1'b0;
            subi_slot_reg      <= '0;
            min_level_reg      <= '0;
            min_level_slot_reg <= '0;
            min_age_reg        <= '0;
            min_age_slot_reg   <= '0;
        end
        else if (ctl.clear)
        begin
            free_found_reg <= 1'b0;
            fmi_found_reg  <= 1'b0;
            subi_found_reg <= 1'b0;
        end
        else if (ctl.upd)
        begin
            if (!entry.fm_active && !entry.sub_active && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= ctl.idx;
            end
            if (!entry.fm_active && !fmi_found_reg)
            begin
                fmi_found_reg <= 1'b1;
                fmi_slot_reg  <= ctl.idx;
            end
            if (!entry.sub_active && !subi_found_reg)
            begin
                subi_found_reg <= 1'b1;
                subi_slot_reg  <= ctl.idx;
            end
            // strict compare: lowest slot wins ties
            if (first || (entry.level < min_level_reg))
            begin
                min_level_reg      <= entry.level;
                min_level_slot_reg <= ctl.idx;
            end
            if (first || (entry.age < min_age_reg))
            begin
                min_age_reg      <= entry.age;
                min_age_slot_reg <= ctl.idx;
            end
        end
    end

    always_comb
    begin
        pick_stolen = !free_found_reg;
        if (free_found_reg)
        begin
            pick_slot = free_slot_reg;
        end
        else if (fm)
        begin
            pick_slot = fmi_found_reg ? fmi_slot_reg : min_level_slot_reg;
        end
        else
        begin
            pick_slot = subi_found_reg ? subi_slot_reg : min_age_slot_reg;
        end
    end

endmodule

// ===== src/sva_ctrl.sv =====
// Command sequencer: slot sweeps, read-modify-write and result generation.
module sva_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sva_pkg::CMD_W-1:0]    cmd,
    input  logic [sva_pkg::NOTE_W-1:0]   note,
    input  logic [sva_pkg::VEL_W-1:0]    velocity,
    input  logic                         engine,
    input  logic [sva_pkg::SLOT_W-1:0]   slot_index,
    input  logic [sva_pkg::LEVEL_W-1:0]  level,
    output logic                         busy,
    output sva_pkg::result_t             res,
    output sva_pkg::ram_req_t            req,
    input  sva_pkg::entry_t              rd_entry,
    output sva_pkg::scan_ctl_t           scan,
    output logic                         scan_fm,
    input  logic [sva_pkg::SLOT_W-1:0]   pick_slot,
    input  logic                         pick_stolen
);
    import sva_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SCAN   = 8'b00000010,
        ST_PICK   = 8'b00000100,
        ST_EMIT   = 8'b00001000,
        ST_SWEEP  = 8'b00010000,
        ST_FLUSH  = 8'b00100000,
        ST_RMW_RD = 8'b01000000,
        ST_RMW_WR = 8'b10000000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_q_reg, cmd_q_next;
    logic [NOTE_W-1:0]  note_q_reg, note_q_next;
    logic [VEL_W-1:0]   vel_q_reg, vel_q_next;
    logic               fm_q_reg, fm_q_next;
    logic [SLOT_W-1:0]  si_q_reg, si_q_next;
    logic [LEVEL_W-1:0] lvl_q_reg, lvl_q_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               issue_reg, issue_next;
    logic               rdv_reg, rdv_next;
    logic [SLOT_W-1:0]  ridx_reg, ridx_next;
    logic [PH_W-1:0]    ph_reg, ph_next;
    logic               buf_valid_reg, buf_valid_next;
    logic [SLOT_W-1:0]  buf_slot_reg, buf_slot_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    result_t            res_reg, res_next;

    entry_t             upd_entry;
    logic               other_active;
    logic [PH_W-1:0]    last_ph;
    logic               match;
    logic               under_cap;
    act_t               rel_act;

    assign busy    = (state_reg != ST_IDLE);
    assign res     = res_reg;
    assign scan_fm = fm_q_reg;
    assign rel_act = fm_q_reg ? ACT_RELEASE_FM : ACT_RELEASE_SUB;

    assign other_active = fm_q_reg ? rd_entry.sub_active : rd_entry.fm_active;
    assign last_ph      = PH_W'(pick_stolen) + PH_W'(other_active);
    assign match        = (rd_entry.note == {1'b0, note_q_reg});
    assign under_cap    = (int'(cnt_reg) < MAX_RESULTS);

    always_comb
    begin
        state_next     = state_reg;
        cmd_q_next     = cmd_q_reg;
        note_q_next    = note_q_reg;
        vel_q_next     = vel_q_reg;
        fm_q_next      = fm_q_reg;
        si_q_next      = si_q_reg;
        lvl_q_next     = lvl_q_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        ph_next        = ph_reg;
        buf_valid_next = buf_valid_reg;
        buf_slot_next  = buf_slot_reg;
        cnt_next       = cnt_reg;
        age_next       = age_reg;
        res_next       = '0;
        req            = '0;
        req.rd_addr    = idx_reg;
        scan           = '0;
        scan.idx       = ridx_reg;
        upd_entry      = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_q_next  = cmd_t'(cmd);
                    note_q_next = note;
                    vel_q_next  = velocity;
                    fm_q_next   = engine;
                    si_q_next   = slot_index;
                    lvl_q_next  = level;
                    unique case (cmd_t'(cmd)) inside
                        CMD_NOTE_ON:
                        begin
                            idx_next   = FIRST_SLOT;
                            issue_next = 1'b1;
                            scan.clear = 1'b1;
                            state_next = ST_SCAN;
                        end
                        CMD_NOTE_OFF:
                        begin
                            idx_next       = FIRST_SLOT;
                            issue_next     = 1'b1;
                            buf_valid_next = 1'b0;
                            cnt_next       = '0;
                            state_next     = ST_SWEEP;
                        end
                        CMD_PANIC:
                        begin
                            idx_next   = '0;
                            issue_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        CMD_VOICE_DONE, CMD_LEVEL_REP:
                        begin
                            if (int'(slot_index) < NUM_VOICES)
                            begin
                                state_next = ST_RMW_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                req.rd_en = issue_reg;
                if (issue_reg)
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                    if (idx_reg == LAST_SLOT)
                    begin
                        issue_next = 1'b0;
                    end
                end
                scan.upd = rdv_reg;
                if (rdv_reg && (ridx_reg == LAST_SLOT))
                begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = pick_slot;
                ph_next     = '0;
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                res_next.valid  = 1'b1;
                res_next.slot   = pick_slot;
                res_next.stolen = pick_stolen;
                res_next.last   = (ph_reg == last_ph);
                if (pick_stolen && (ph_reg == '0))
                begin
                    res_next.action = rel_act;
                end
                else if (ph_reg == PH_W'(pick_stolen))
                begin
                    res_next.action   = fm_q_reg ? ACT_START_FM : ACT_START_SUB;
                    res_next.note     = note_q_reg;
                    res_next.velocity = vel_q_reg;
                end
                else
                begin
                    res_next.action = fm_q_reg ? ACT_RELEASE_SUB : ACT_RELEASE_FM;
                end
                ph_next = ph_reg + PH_W'(1);
                if (ph_reg == last_ph)
                begin
                    if (fm_q_reg)
                    begin
                        upd_entry.fm_active = 1'b1;
                    end
                    else
                    begin
                        upd_entry.sub_active = 1'b1;
                    end
                    upd_entry.note = {1'b0, note_q_reg};
                    upd_entry.age  = age_reg + AGE_W'(1);
                    age_next       = age_reg + AGE_W'(1);
                    req.wr_en      = 1'b1;
                    req.wr_addr    = pick_slot;
                    req.wr_data    = upd_entry;
                    state_next     = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                req.rd_en = issue_reg;
                if (issue_reg)
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                    if (idx_reg == LAST_SLOT)
                    begin
                        issue_next = 1'b0;
                    end
                end
                upd_entry.note = NO_NOTE;
                req.wr_addr    = ridx_reg;
                req.wr_data    = upd_entry;
                if (rdv_reg)
                begin
                    if (cmd_q_reg == CMD_PANIC)
                    begin
                        req.wr_en = 1'b1;
                        if (ridx_reg == LAST_SLOT)
                        begin
                            res_next.valid  = 1'b1;
                            res_next.slot   = '0;
                            res_next.action = ACT_RELEASE_ALL;
                            res_next.last   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        req.wr_en = match;
                        // one release held back so the final one can carry last
                        if (match && under_cap)
                        begin
                            if (buf_valid_reg)
                            begin
                                res_next.valid  = 1'b1;
                                res_next.slot   = buf_slot_reg;
                                res_next.action = rel_act;
                            end
                            buf_valid_next = 1'b1;
                            buf_slot_next  = ridx_reg;
                            cnt_next       = cnt_reg + CNT_W'(1);
                        end
                        if (ridx_reg == LAST_SLOT)
                        begin
                            if (match && under_cap)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                if (buf_valid_reg)
                                begin
                                    res_next.valid  = 1'b1;
                                    res_next.slot   = buf_slot_reg;
                                    res_next.action = rel_act;
                                    res_next.last   = 1'b1;
                                end
                                buf_valid_next = 1'b0;
                                state_next     = ST_IDLE;
                            end
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                res_next.valid  = 1'b1;
                res_next.slot   = buf_slot_reg;
                res_next.action = rel_act;
                res_next.last   = 1'b1;
                buf_valid_next  = 1'b0;
                state_next      = ST_IDLE;
            end

            ST_RMW_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = si_q_reg;
                state_next  = ST_RMW_WR;
            end

            ST_RMW_WR:
            begin
                if (cmd_q_reg == CMD_LEVEL_REP)
                begin
                    upd_entry.level = lvl_q_reg;
                end
                else if (fm_q_reg)
                begin
                    upd_entry.fm_active = 1'b0;
                end
                else
                begin
                    upd_entry.sub_active = 1'b0;
                end
                req.wr_en   = 1'b1;
                req.wr_addr = si_q_reg;
                req.wr_data = upd_entry;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rdv_next  = req.rd_en;
        ridx_next = req.rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            rdv_reg       <= 1'b0;
            ridx_reg      <= '0;
            idx_reg       <= '0;
            ph_reg        <= '0;
            buf_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            age_reg       <= '0;
            res_reg       <= '0;
            cmd_q_reg     <= CMD_NOTE_ON;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            rdv_reg       <= rdv_next;
            ridx_reg      <= ridx_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            buf_valid_reg <= buf_valid_next;
            cnt_reg       <= cnt_next;
            age_reg       <= age_next;
            res_reg       <= res_next;
            cmd_q_reg     <= cmd_q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_q_reg   <= note_q_next;
        vel_q_reg    <= vel_q_next;
        fm_q_reg     <= fm_q_next;
        si_q_reg     <= si_q_next;
        lvl_q_reg    <= lvl_q_next;
        buf_slot_reg <= buf_slot_next;
    end

endmodule

// ===== tb/sv/tb_synth_voice_allocator_unit.sv =====
// Self-checking testbench for the voice allocator: directed and random requests, scoreboard.
module tb_synth_voice_allocator_unit;

    import sva_pkg::*;

    // Cycles without any accepted request or result before the run is declared hung.
    // Sender gaps are geometric.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last expected action: covers a trailing voice_done/level_report.
    localparam int TAIL_CYCLES    = 40;
    // cmd codes above panic are not decoded by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int RANDOM_PER_PHASE = 48;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    cmd = '0;
    logic [NOTE_W-1:0]   note = '0;
    logic [VEL_W-1:0]    velocity = '0;
    logic                engine = 1'b0;
    logic [SLOT_W-1:0]   slot_index = '0;
    logic [LEVEL_W-1:0]  level = '0;
    logic                strobe;
    logic [SLOT_W-1:0]   slot;
    logic [2:0]          action;
    logic [NOTE_W-1:0]   note_out;
    logic [VEL_W-1:0]    velocity_out;
    logic                stolen;
    logic                last;

    // One expected action as it should appear on the result ports.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        act_t              action;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              stolen;
        logic              last;
    } voice_action_t;

    // Shadow copy of the slot table; predicts the actions of each accepted request
    // and checks the block's actions against them in order.
    class voice_action_board;
        bit                 fm_on     [NUM_VOICES];
        bit                 sub_on    [NUM_VOICES];
        logic [SNOTE_W-1:0] held_note [NUM_VOICES];
        logic [AGE_W-1:0]   slot_age  [NUM_VOICES];
        logic [LEVEL_W-1:0] fm_quiet  [NUM_VOICES];
        logic [AGE_W-1:0]   age_ctr;
        voice_action_t      pending_actions [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                fm_on[i]     = 1'b0;
                sub_on[i]    = 1'b0;
                held_note[i] = NO_NOTE;
                slot_age[i]  = '0;
                fm_quiet[i]  = '0;
            end
            age_ctr    = '0;
            mismatches = 0;
        endfunction

        function void push_action(int s, act_t a, logic [NOTE_W-1:0] n,
                                  logic [VEL_W-1:0] v, logic stl);
            voice_action_t r;
            r.slot     = SLOT_W'(s);
            r.action   = a;
            r.note     = n;
            r.velocity = v;
            r.stolen   = stl;
            r.last     = 1'b0;
            pending_actions.push_back(r);
        endfunction

        // Slot for a note_on that finds no free slot: first idle voice of the
        // engine, else quietest FM level / oldest sub age, lowest slot on ties.
        function int steal_slot(logic fm);
            logic [AGE_W:0] best_v;
            logic [AGE_W:0] v;
            int             best;
            best   = 1;
            best_v = '1;
            for (int i = 1; i < NUM_VOICES; i++)
            begin
                if (fm ? !fm_on[i] : !sub_on[i])
                    return i;
                v = fm ? (AGE_W+1)'(fm_quiet[i]) : (AGE_W+1)'(slot_age[i]);
                if (v < best_v)
                begin
                    best_v = v;
                    best   = i;
                end
            end
            return best;
        endfunction

        function void note_request(logic [CMD_W-1:0] c, logic [NOTE_W-1:0] n,
                                   logic [VEL_W-1:0] v, logic fm,
                                   logic [SLOT_W-1:0] si, logic [LEVEL_W-1:0] lv);
            int   s;
            int   queued;
            logic stl;
            queued = pending_actions.size();
            case (c)
                CMD_NOTE_ON:
                begin
                    s   = -1;
                    stl = 1'b0;
                    for (int i = 1; i < NUM_VOICES; i++)
                        if (s < 0 && !fm_on[i] && !sub_on[i])
                            s = i;
                    if (s < 0)
                    begin
                        s   = steal_slot(fm);
                        stl = 1'b1;
                        push_action(s, fm ? ACT_RELEASE_FM : ACT_RELEASE_SUB, '0, '0, 1'b1);
                    end
                    push_action(s, fm ? ACT_START_FM : ACT_START_SUB, n, v, stl);
                    if (fm)
                    begin
                        fm_on[s] = 1'b1;
                        if (sub_on[s])
                            push_action(s, ACT_RELEASE_SUB, '0, '0, stl);
                    end
                    else
                    begin
                        sub_on[s] = 1'b1;
                        if (fm_on[s])
                            push_action(s, ACT_RELEASE_FM, '0, '0, stl);
                    end
                    held_note[s] = {1'b0, n};
                    age_ctr      = age_ctr + 1'b1;
                    slot_age[s]  = age_ctr;
                end
                CMD_NOTE_OFF:
                begin
                    // releases go out whether or not the voice is still sounding
                    for (int i = 1; i < NUM_VOICES; i++)
                        if (held_note[i] == {1'b0, n})
                        begin
                            if (pending_actions.size() - queued < MAX_RESULTS)
                                push_action(i, fm ? ACT_RELEASE_FM : ACT_RELEASE_SUB,
                                            '0, '0, 1'b0);
                            held_note[i] = NO_NOTE;
                        end
                end
                CMD_VOICE_DONE:
                begin
                    if (fm)
                        fm_on[si] = 1'b0;
                    else
                        sub_on[si] = 1'b0;
                end
                CMD_LEVEL_REP: fm_quiet[si] = lv;
                CMD_PANIC:
                begin
                    // notes forgotten, voices keep sounding
                    for (int i = 0; i < NUM_VOICES; i++)
                        held_note[i] = NO_NOTE;
                    push_action(0, ACT_RELEASE_ALL, '0, '0, 1'b0);
                end
                default: ;
            endcase
            if (pending_actions.size() > queued)
                pending_actions[pending_actions.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_action(logic [SLOT_W-1:0] s, logic [2:0] a, logic [NOTE_W-1:0] n,
                          logic [VEL_W-1:0] v, logic stl, logic lst);
            voice_action_t want;
            if (pending_actions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected action %0d on slot %0d", a, s));
                return;
            end
            want = pending_actions.pop_front();
            if (s !== want.slot)
                report_mismatch($sformatf("slot %0d, want %0d", s, want.slot));
            if (a !== want.action)
                report_mismatch($sformatf("action %0d, want %s", a, want.action.name()));
            if (n !== want.note)
                report_mismatch($sformatf("note_out %0d, want %0d", n, want.note));
            if (v !== want.velocity)
                report_mismatch($sformatf("velocity_out %0d, want %0d", v, want.velocity));
            if (stl !== want.stolen)
                report_mismatch($sformatf("stolen %b, want %b", stl, want.stolen));
            if (lst !== want.last)
                report_mismatch($sformatf("last %b, want %b", lst, want.last));
        endtask
    endclass

    voice_action_board board;
    int requests_sent = 0;
    int actions_seen  = 0;
    int steals_seen   = 0;
    int idle_cycles   = 0;

    synth_voice_allocator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .note         (note),
        .velocity     (velocity),
        .engine       (engine),
        .slot_index   (slot_index),
        .level        (level),
        .strobe       (strobe),
        .slot         (slot),
        .action       (action),
        .note_out     (note_out),
        .velocity_out (velocity_out),
        .stolen       (stolen),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: outputs are read right at the rising edge, before any update of
    // that edge lands, so a request is taken when start is high and busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.note_request(cmd, note, velocity, engine, slot_index, level);
                requests_sent++;
            end
            if (strobe)
            begin
                board.check_action(slot, action, note_out, velocity_out, stolen, last);
                actions_seen++;
                if (stolen && (action == ACT_START_FM || action == ACT_START_SUB))
                    steals_seen++;
            end
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Drive one request and hold it until taken; then maybe leave start low
    // for a random stretch (gap_pct is the per-cycle idle chance).
    task automatic send_request(input logic [CMD_W-1:0] c, input logic [NOTE_W-1:0] n,
                                input logic [VEL_W-1:0] v, input logic e,
                                input logic [SLOT_W-1:0] si, input logic [LEVEL_W-1:0] lv,
                                input int gap_pct);
        start      <= 1'b1;
        cmd        <= c;
        note       <= n;
        velocity   <= v;
        engine     <= e;
        slot_index <= si;
        level      <= lv;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Random request. Notes come mostly from a small pool so note_off finds
    // several holders; levels favor equal values to exercise steal ties.
    task automatic send_random(input int gap_pct);
        int                 roll;
        logic [CMD_W-1:0]   c;
        logic [NOTE_W-1:0]  n;
        logic [LEVEL_W-1:0] lv;
        roll = $urandom_range(99);
        if (roll < 38)
            c = CMD_NOTE_ON;
        else if (roll < 53)
            c = CMD_NOTE_OFF;
        else if (roll < 78)
            c = CMD_VOICE_DONE;
        else if (roll < 92)
            c = CMD_LEVEL_REP;
        else if (roll < 96)
            c = CMD_PANIC;
        else
            c = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        roll = $urandom_range(99);
        if (roll < 75)
            n = NOTE_W'($urandom_range(7));
        else if (roll < 87)
            n = NOTE_W'(127 - $urandom_range(3));
        else
            n = NOTE_W'($urandom_range(127));
        case ($urandom_range(3))
            0:       lv = '0;
            1:       lv = '1;
            2:       lv = LEVEL_W'($urandom_range(3));
            default: lv = LEVEL_W'($urandom);
        endcase
        send_request(c, n, VEL_W'($urandom_range(1023)), 1'($urandom_range(1)),
                     SLOT_W'($urandom_range(NUM_VOICES - 1)), lv, gap_pct);
    endtask

    initial
    begin
        int gap_pct [4];
        board = new();
        // sender idle chance per phase; the result side has no back-pressure,
        // so the third phase just runs back-to-back again
        gap_pct = '{0, 50, 0, 22};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: panic on an empty table, level extremes on slots 0 and 15,
        // then fill slots 1 to 15 so the following note_ons must steal.
        send_request(CMD_PANIC, '0, '0, 1'b0, '0, '0, 0);
        send_request(CMD_LEVEL_REP, '0, '0, 1'b1, LAST_SLOT, '1, 0);
        send_request(CMD_LEVEL_REP, '0, '0, 1'b1, '0, '0, 0);
        for (int k = 1; k < NUM_VOICES; k++)
            send_request(CMD_NOTE_ON,
                         (k % 4 == 0) ? NOTE_W'(60) :
                         (k == 1) ? NOTE_W'(0) : (k == 2) ? NOTE_W'(127) : NOTE_W'(20 + k),
                         (k == 1) ? VEL_W'(0) : (k == 2) ? VEL_W'(1023) : VEL_W'(k * 61),
                         1'(k % 2), '0, '0, 0);
        // steal onto an idle FM voice of a sub-only slot, then the mirror case
        send_request(CMD_NOTE_ON, NOTE_W'(64), VEL_W'(512), 1'b1, '0, '0, 0);
        send_request(CMD_NOTE_ON, NOTE_W'(65), VEL_W'(300), 1'b0, '0, '0, 0);
        // one note held by several slots
        send_request(CMD_NOTE_OFF, NOTE_W'(60), '0, 1'b1, '0, '0, 0);
        send_request(CMD_VOICE_DONE, '0, '0, 1'b1, LAST_SLOT, '0, 0);
        send_request(CMD_VOICE_DONE, '0, '0, 1'b0, '0, '0, 0);
        send_request(CMD_UNUSED_LO, NOTE_W'(127), '1, 1'b1, '1, '1, 0);
        send_request(CMD_UNUSED_HI, NOTE_W'(127), '1, 1'b1, '1, '1, 0);
        send_request(CMD_PANIC, '0, '0, 1'b0, '0, '0, 0);
        // after a panic no slot holds any note
        send_request(CMD_NOTE_OFF, NOTE_W'(0), '0, 1'b0, '0, '0, 0);

        for (int p = 0; p < 4; p++)
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_random(gap_pct[p]);
        start <= 1'b0;

        while (board.pending_actions.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests taken, %0d actions checked, %0d note_ons resolved by stealing",
                 requests_sent, actions_seen, steals_seen);
        $display("sender idling phases: 0, 50, 0 and 22 percent; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
